[design/eppts_pkg.sv]
// ----------------------------------------------------------------------------
// eppts_pkg
// Shared types, register codes and helpers for the pixel trajectory step.
// ----------------------------------------------------------------------------
package eppts_pkg;

    localparam int PIX     = 4;   // pixels per request, 1 to 8
    localparam int NIB_W   = 4;
    localparam int DRIVE_W = 8;
    localparam int ACC_W   = 16;  // drive accumulator, as wide as 8 pixel pairs
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [NIB_W-1:0] nib_t;
    typedef nib_t [PIX-1:0]   nib_vec_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GREY_TABLE  = 3'd0,
        REG_TRAVEL_GAIN = 3'd1,
        REG_BOOST       = 3'd2,
        REG_RESTED      = 3'd3,
        REG_FINE_HOLD   = 3'd4,
        REG_FRAME_STEP  = 3'd5
    } cfg_reg_t;

    localparam logic [1:0] DRV_HOLD    = 2'b00;
    localparam logic [1:0] DRV_DARKEN  = 2'b01;
    localparam logic [1:0] DRV_LIGHTEN = 2'b10;

    // grey k -> position, nibble k: 0,1,1,2,2,2,3,3,3,4,4,4,5,5,6,8
    localparam logic [63:0] RST_GREY_TABLE = 64'h8655_4443_3322_2110;
    localparam nib_t        RST_GAIN       = 4'd1;
    localparam nib_t        RST_STEP       = 4'd1;

    typedef struct packed {
        logic [63:0] grey_table;
        nib_t        travel_gain;
        logic        boost_enable;
        logic        rested_mode;
        logic        fine_hold;
        nib_t        frame_step;
    } cfg_t;

    // Stage 1 -> 2: positions and looked-up targets
    typedef struct packed {
        nib_vec_t cur;
        nib_vec_t tgt;
    } s1_t;

    // Stage 2 -> 3: moved positions, targets, per-pixel drive
    typedef struct packed {
        nib_vec_t         nxt;
        nib_vec_t         tgt;
        logic [2*PIX-1:0] drv;  // pixel i at [2i+1:2i]
    } s2_t;

    // Stage 3 -> port
    typedef struct packed {
        nib_vec_t           pos;
        logic [DRIVE_W-1:0] drive;
        logic               active;
        logic               drove;
        logic               coarse;
        logic               fine;
    } s3_t;

    function automatic nib_t abs_diff(input nib_t a, input nib_t b);
        return (a > b) ? nib_t'(a - b) : nib_t'(b - a);
    endfunction

endpackage

[design/eppts_cfg.sv]
// ----------------------------------------------------------------------------
// eppts_cfg
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module eppts_cfg
    import eppts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_GREY_TABLE:  cfg_next.grey_table   = wr_data;
                REG_TRAVEL_GAIN: cfg_next.travel_gain  = wr_data[NIB_W-1:0];
                REG_BOOST:       cfg_next.boost_enable = wr_data[0];
                REG_RESTED:      cfg_next.rested_mode  = wr_data[0];
                REG_FINE_HOLD:   cfg_next.fine_hold    = wr_data[0];
                REG_FRAME_STEP:  cfg_next.frame_step   = wr_data[NIB_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grey_table   <= RST_GREY_TABLE;
            cfg_reg.travel_gain  <= RST_GAIN;
            cfg_reg.boost_enable <= 1'b0;
            cfg_reg.rested_mode  <= 1'b0;
            cfg_reg.fine_hold    <= 1'b0;
            cfg_reg.frame_step   <= RST_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/eppts_lookup.sv]
// ----------------------------------------------------------------------------
// eppts_lookup
// Stage 1: grey-to-position table lookup per pixel.
// ----------------------------------------------------------------------------
module eppts_lookup
    import eppts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        up_valid,
    output logic        up_ready,
    input  nib_vec_t    cur,
    input  nib_vec_t    grey,
    output logic        dn_valid,
    input  logic        dn_ready,
    output s1_t         dn_data
);

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;
    logic load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        for (int i = 0; i < PIX; i++)
        begin
            data_next.cur[i] = cur[i];
            data_next.tgt[i] = cfg.grey_table[NIB_W*grey[i] +: NIB_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[design/eppts_move.sv]
// ----------------------------------------------------------------------------
// eppts_move
// Stage 2: step size choice, position update and drive code per pixel.
// ----------------------------------------------------------------------------
module eppts_move
    import eppts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic up_valid,
    output logic up_ready,
    input  s1_t  up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output s2_t  dn_data
);

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;
    logic load;
    logic boosted;
    logic win_ok;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign boosted  = (cfg.travel_gain > nib_t'(1)) && cfg.boost_enable;
    // unit frame step is also blocked by fine hold
    assign win_ok   = (cfg.frame_step > nib_t'(1)) || !cfg.fine_hold;

    always_comb
    begin
        nib_t gap;
        nib_t step;
        nib_t cv;
        nib_t tv;
        for (int i = 0; i < PIX; i++)
        begin
            cv   = up_data.cur[i];
            tv   = up_data.tgt[i];
            gap  = abs_diff(cv, tv);
            step = '0;
            if (gap != '0)
            begin
                if (cfg.rested_mode)
                begin
                    if (boosted && gap >= cfg.travel_gain)
                        step = cfg.travel_gain;
                    else
                        step = cfg.fine_hold ? nib_t'(0) : nib_t'(1);
                end
                else if (gap >= cfg.frame_step && win_ok)
                begin
                    step = cfg.frame_step;
                end
            end
            data_next.tgt[i]        = tv;
            data_next.nxt[i]        = cv;
            data_next.drv[2*i +: 2] = DRV_HOLD;
            if (step != '0)
            begin
                if (cv < tv)
                begin
                    data_next.nxt[i]        = nib_t'(cv + step);
                    data_next.drv[2*i +: 2] = DRV_DARKEN;
                end
                else
                begin
                    data_next.nxt[i]        = nib_t'(cv - step);
                    data_next.drv[2*i +: 2] = DRV_LIGHTEN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[design/eppts_flags.sv]
// ----------------------------------------------------------------------------
// eppts_flags
// Stage 3: drive packing, merged status flags, output register.
// ----------------------------------------------------------------------------
module eppts_flags
    import eppts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic up_valid,
    output logic up_ready,
    input  s2_t  up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output s3_t  dn_data
);

    logic valid_reg;
    s3_t  data_reg;
    s3_t  data_next;
    logic load;
    logic boosted;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign boosted  = (cfg.travel_gain > nib_t'(1)) && cfg.boost_enable;

    always_comb
    begin
        logic [ACC_W-1:0] acc;
        nib_t             rem;
        acc                = '0;
        data_next.active   = 1'b0;
        data_next.drove    = 1'b0;
        data_next.coarse   = 1'b0;
        data_next.fine     = 1'b0;
        for (int i = 0; i < PIX; i++)
        begin
            data_next.pos[i] = up_data.nxt[i];
            // first pixel ends up in the highest pair
            acc = {acc[ACC_W-3:0], up_data.drv[2*i +: 2]};
            if (up_data.drv[2*i +: 2] != DRV_HOLD)
                data_next.drove = 1'b1;
            rem = abs_diff(up_data.nxt[i], up_data.tgt[i]);
            if (rem != '0)
            begin
                data_next.active = 1'b1;
                if (!cfg.rested_mode)
                begin
                    if (boosted && rem >= cfg.travel_gain)
                        data_next.coarse = 1'b1;
                    else
                        data_next.fine = 1'b1;
                end
            end
        end
        data_next.drive = acc[DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[design/epaper_pixel_trajectory_step.sv]
// ----------------------------------------------------------------------------
// epaper_pixel_trajectory_step
// Advances four e-paper pixels by one drive tick per request.
// ----------------------------------------------------------------------------
// One request carries four pixels (current position and target grey) and
// yields their new positions, a packed drive byte (first pixel in bits 7:6;
// 01 darken, 10 lighten, 00 hold) and OR-merged status flags. The block is a
// three-stage pipeline: table lookup, step/move, then flag merge into the
// output register. It takes one request every cycle while in_stall is low.
// Each stage register loads whenever it is empty or its successor takes its
// content, so bubbles close up under output stall and up to three requests
// sit in flight. Registers are written over the cfg port, which is always
// ready; write them only while the pipeline is empty, since the stages read
// the live register values.
// ----------------------------------------------------------------------------
module epaper_pixel_trajectory_step
    import eppts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // request side
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [NIB_W-1:0]      cur_pos_0,
    input  logic [NIB_W-1:0]      cur_pos_1,
    input  logic [NIB_W-1:0]      cur_pos_2,
    input  logic [NIB_W-1:0]      cur_pos_3,
    input  logic [NIB_W-1:0]      grey_0,
    input  logic [NIB_W-1:0]      grey_1,
    input  logic [NIB_W-1:0]      grey_2,
    input  logic [NIB_W-1:0]      grey_3,

    // result side
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [NIB_W-1:0]      new_pos_0,
    output logic [NIB_W-1:0]      new_pos_1,
    output logic [NIB_W-1:0]      new_pos_2,
    output logic [NIB_W-1:0]      new_pos_3,
    output logic [DRIVE_W-1:0]    drive_byte,
    output logic                  still_active,
    output logic                  drove_any,
    output logic                  want_coarse,
    output logic                  want_fine
);

    cfg_t     cfg;
    nib_vec_t cur;
    nib_vec_t grey;

    logic     s1_valid, s1_ready, in_ready;
    s1_t      s1_data;
    logic     s2_valid, s2_ready;
    s2_t      s2_data;
    s3_t      s3_data;

    assign cfg_ready = 1'b1;

    eppts_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cur  = {cur_pos_3, cur_pos_2, cur_pos_1, cur_pos_0};
    assign grey = {grey_3, grey_2, grey_1, grey_0};

    // stage 1: lookup
    eppts_lookup u_lookup (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .cur      (cur),
        .grey     (grey),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    assign in_stall = !in_ready;

    // stage 2: move
    eppts_move u_move (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    // stage 3: flags, doubles as the output register
    eppts_flags u_flags (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .dn_data  (s3_data)
    );

    assign new_pos_0    = s3_data.pos[0];
    assign new_pos_1    = s3_data.pos[1];
    assign new_pos_2    = s3_data.pos[2];
    assign new_pos_3    = s3_data.pos[3];
    assign drive_byte   = s3_data.drive;
    assign still_active = s3_data.active;
    assign drove_any    = s3_data.drove;
    assign want_coarse  = s3_data.coarse;
    assign want_fine    = s3_data.fine;

    // drove_any must agree with the packed drive codes
    a_drove_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drove_any == (drive_byte != '0)))
        else $error("drove_any disagrees with drive_byte");

    // work flags only come from unsettled pixels
    a_flags_need_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !still_active) |-> (!want_coarse && !want_fine))
        else $error("coarse/fine flag without active pixel");

    // a pixel is never driven both ways
    a_no_double_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((drive_byte[1:0] != 2'b11) && (drive_byte[3:2] != 2'b11)
                    && (drive_byte[5:4] != 2'b11) && (drive_byte[7:6] != 2'b11)))
        else $error("illegal drive code");

    // a full pipeline with a stalled output must push back on requests
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && s1_valid && s2_valid) |-> in_stall)
        else $error("request taken while pipeline full");

endmodule

[dv/epaper_pixel_trajectory_step_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epaper_pixel_trajectory_step_tb
// Self-checking bench for the e-paper pixel trajectory step.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests runs first across a handful of
// register settings (reset defaults, rested boost, rested fine hold, frame
// step zero, windowed fine hold, windowed coarse, widest step). Then random
// phases follow, each with its own register setting, where most pixels walk
// a trajectory: the next request feeds back the predicted new position.
// Every result is compared field by field against the in-order prediction.
// ----------------------------------------------------------------------------
module epaper_pixel_trajectory_step_tb;
    import eppts_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 5;    // three stages plus margin
    localparam int PHASE_COUNT     = 10;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int SQUEEZE_PHASE   = 4;    // phase with the long output hold-off
    localparam int HOLD_OFF_CYCLES = 120;

    // register indexes outside the map; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // directed register settings
    localparam logic [2:0] SET_RESET        = 3'd0;
    localparam logic [2:0] SET_RESTED_BOOST = 3'd1;
    localparam logic [2:0] SET_RESTED_HOLD  = 3'd2;
    localparam logic [2:0] SET_STEP_ZERO    = 3'd3;
    localparam logic [2:0] SET_WIN_HOLD     = 3'd4;
    localparam logic [2:0] SET_WIN_COARSE   = 3'd5;
    localparam logic [2:0] SET_WIDE         = 3'd6;

    localparam logic [63:0] IDENTITY_TABLE = 64'hFEDC_BA98_7654_3210;

    // pixel 0 is the leftmost nibble, so 16'h5A3C reads pixel 0 = 5
    typedef nib_t [0:PIX-1] pix_vec_t;

    typedef struct packed {
        pix_vec_t           pos;
        logic [DRIVE_W-1:0] drive;
        logic               active;
        logic               drove;
        logic               coarse;
        logic               fine;
    } step_res_t;

    typedef struct packed {
        logic [2:0] setting;
        pix_vec_t   cur;
        pix_vec_t   grey;
        logic       known;   // expectation typed in below, else predicted
        step_res_t  res;
    } dir_row_t;

    localparam int DIR_SETTINGS = 7;
    localparam int DIR_ROWS     = 19;

    cfg_t dir_cfgs [DIR_SETTINGS] = '{
        '{RST_GREY_TABLE, RST_GAIN, 1'b0, 1'b0, 1'b0, RST_STEP},
        '{RST_GREY_TABLE, 4'd3,     1'b1, 1'b1, 1'b0, RST_STEP},
        '{RST_GREY_TABLE, 4'd1,     1'b0, 1'b1, 1'b1, RST_STEP},
        '{RST_GREY_TABLE, RST_GAIN, 1'b0, 1'b0, 1'b0, 4'd0},
        '{RST_GREY_TABLE, 4'd1,     1'b0, 1'b0, 1'b1, 4'd1},
        '{IDENTITY_TABLE, 4'd4,     1'b1, 1'b0, 1'b0, 4'd4},
        '{IDENTITY_TABLE, 4'd15,    1'b1, 1'b0, 1'b1, 4'd15}
    };

    dir_row_t dir_rows [DIR_ROWS] = '{
        // reset defaults: everything at target
        '{SET_RESET, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        // all darken one unit from the bottom
        '{SET_RESET, 16'h0000, 16'hFFFF, 1'b1, '{16'h1111, 8'h55, 1'b1, 1'b1, 1'b0, 1'b1}},
        // all lighten one unit from the top
        '{SET_RESET, 16'hFFFF, 16'h0000, 1'b1, '{16'hEEEE, 8'hAA, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{SET_RESET, 16'hFFFF, 16'hFFFF, 1'b1, '{16'hEEEE, 8'hAA, 1'b1, 1'b1, 1'b0, 1'b1}},
        // only the third pixel moves
        '{SET_RESET, 16'h08F1, 16'h0F01, 1'b1, '{16'h08E1, 8'h08, 1'b1, 1'b1, 1'b0, 1'b1}},
        // first pixel lands on its target: drove without staying active
        '{SET_RESET, 16'h1000, 16'h0000, 1'b1, '{16'h0000, 8'h80, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{SET_RESET, 16'h5A3C, 16'h72E9, 1'b0, '0},
        '{SET_RESET, 16'h8926, 16'hFF35, 1'b0, '0},
        '{SET_RESTED_BOOST, 16'h0F72, 16'hF093, 1'b0, '0},
        '{SET_RESTED_BOOST, 16'h149D, 16'hEF1C, 1'b0, '0},
        // rested with fine hold and no boost: nothing moves, only the active flag is set
        '{SET_RESTED_HOLD, 16'h0000, 16'hFFFF, 1'b1, '{16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{SET_RESTED_HOLD, 16'h3280, 16'h30C1, 1'b0, '0},
        // frame step zero: no move, but the work is still classed as fine
        '{SET_STEP_ZERO, 16'h0000, 16'hFFFF, 1'b1, '{16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{SET_STEP_ZERO, 16'hF417, 16'h092D, 1'b0, '0},
        '{SET_WIN_HOLD, 16'h03F6, 16'hF609, 1'b0, '0},
        '{SET_WIN_COARSE, 16'h00F9, 16'hF309, 1'b0, '0},
        '{SET_WIN_COARSE, 16'h52BC, 16'h94E7, 1'b0, '0},
        // full-range jumps in both directions
        '{SET_WIDE, 16'h0F0F, 16'hF00F, 1'b1, '{16'hF00F, 8'h60, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{SET_WIDE, 16'h01E7, 16'hE0F7, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [NIB_W-1:0]      cur_pos_0 = '0;
    logic [NIB_W-1:0]      cur_pos_1 = '0;
    logic [NIB_W-1:0]      cur_pos_2 = '0;
    logic [NIB_W-1:0]      cur_pos_3 = '0;
    logic [NIB_W-1:0]      grey_0 = '0;
    logic [NIB_W-1:0]      grey_1 = '0;
    logic [NIB_W-1:0]      grey_2 = '0;
    logic [NIB_W-1:0]      grey_3 = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [NIB_W-1:0]      new_pos_0;
    logic [NIB_W-1:0]      new_pos_1;
    logic [NIB_W-1:0]      new_pos_2;
    logic [NIB_W-1:0]      new_pos_3;
    logic [DRIVE_W-1:0]    drive_byte;
    logic                  still_active;
    logic                  drove_any;
    logic                  want_coarse;
    logic                  want_fine;

    // shadow of the register file, as the block should hold it
    cfg_t      live_cfg = '{RST_GREY_TABLE, RST_GAIN, 1'b0, 1'b0, 1'b0, RST_STEP};
    step_res_t pending_steps [$];
    step_res_t got_step;
    int        mismatches  = 0;
    int        cycle_count = 0;
    bit        squeeze = 1'b0;   // sender runs flat out, sink holds off once
    bit        quiet   = 1'b0;   // no idling on either side

    epaper_pixel_trajectory_step uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cur_pos_0    (cur_pos_0),
        .cur_pos_1    (cur_pos_1),
        .cur_pos_2    (cur_pos_2),
        .cur_pos_3    (cur_pos_3),
        .grey_0       (grey_0),
        .grey_1       (grey_1),
        .grey_2       (grey_2),
        .grey_3       (grey_3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_pos_0    (new_pos_0),
        .new_pos_1    (new_pos_1),
        .new_pos_2    (new_pos_2),
        .new_pos_3    (new_pos_3),
        .drive_byte   (drive_byte),
        .still_active (still_active),
        .drove_any    (drove_any),
        .want_coarse  (want_coarse),
        .want_fine    (want_fine)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic nib_t target_of(cfg_t c, nib_t g);
        return c.grey_table[4*g +: 4];
    endfunction

    function automatic step_res_t advance_pixels(cfg_t c, pix_vec_t cur, pix_vec_t grey);
        step_res_t  r;
        logic       boosted;
        nib_t       tgt;
        nib_t       gap;
        nib_t       rem;
        nib_t       mv;
        nib_t       nv;
        logic [1:0] drv;
        r = '0;
        boosted = c.boost_enable && (c.travel_gain > 4'd1);
        for (int i = 0; i < PIX; i++)
        begin
            tgt  = target_of(c, grey[i]);
            gap  = (cur[i] > tgt) ? nib_t'(cur[i] - tgt) : nib_t'(tgt - cur[i]);
            mv   = '0;
            if (gap != 0)
            begin
                if (c.rested_mode)
                    mv = (boosted && gap >= c.travel_gain) ? c.travel_gain
                                                           : (c.fine_hold ? 4'd0 : 4'd1);
                // a unit frame step is the fine step, so fine hold blocks it
                else if (gap >= c.frame_step && (c.frame_step > 4'd1 || !c.fine_hold))
                    mv = c.frame_step;
            end
            drv = DRV_HOLD;
            nv  = cur[i];
            if (mv != 0)
            begin
                if (cur[i] < tgt)
                begin
                    drv = DRV_DARKEN;
                    nv  = nib_t'(cur[i] + mv);
                end
                else
                begin
                    drv = DRV_LIGHTEN;
                    nv  = nib_t'(cur[i] - mv);
                end
                r.drove = 1'b1;
            end
            if (nv != tgt)
            begin
                r.active = 1'b1;
                // work classes only exist in windowed mode
                if (!c.rested_mode)
                begin
                    rem = (nv > tgt) ? nib_t'(nv - tgt) : nib_t'(tgt - nv);
                    if (boosted && rem >= c.travel_gain)
                        r.coarse = 1'b1;
                    else
                        r.fine = 1'b1;
                end
            end
            r.drive[DRIVE_W-1-2*i -: 2] = drv;
            r.pos[i] = nv;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Register writes: one handshake, then valid drops before the next write.
    // The shadow copy applies the same field masking as the block.
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GREY_TABLE:  live_cfg.grey_table   = data;
            REG_TRAVEL_GAIN: live_cfg.travel_gain  = data[3:0];
            REG_BOOST:       live_cfg.boost_enable = data[0];
            REG_RESTED:      live_cfg.rested_mode  = data[0];
            REG_FINE_HOLD:   live_cfg.fine_hold    = data[0];
            REG_FRAME_STEP:  live_cfg.frame_step   = data[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Write all six registers, the narrow ones with junk above the field, then poke the
    // unmapped indexes, which must leave the setting alone.
    task automatic apply_cfg(cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_GREY_TABLE, c.grey_table);
        write_reg(REG_TRAVEL_GAIN, {junk[63:4], c.travel_gain});
        write_reg(REG_BOOST, {junk[63:1], c.boost_enable});
        write_reg(REG_RESTED, {~junk[63:1], c.rested_mode});
        write_reg(REG_FINE_HOLD, {junk[62:0], c.fine_hold});
        write_reg(REG_FRAME_STEP, {~junk[63:4], c.frame_step});
        write_reg(REG_SPARE_6, junk);
        write_reg(REG_SPARE_7, ~junk);
    endtask

    // ------------------------------------------------------------------
    // Request side. The payload is set with valid and held until the
    // handshake; the prediction is queued at acceptance.
    // ------------------------------------------------------------------
    task automatic offer(pix_vec_t cur, pix_vec_t grey, step_res_t want);
        in_valid  <= 1'b1;
        cur_pos_0 <= cur[0];
        cur_pos_1 <= cur[1];
        cur_pos_2 <= cur[2];
        cur_pos_3 <= cur[3];
        grey_0    <= grey[0];
        grey_1    <= grey[1];
        grey_2    <= grey[2];
        grey_3    <= grey[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_steps.push_back(want);
    endtask

    task automatic maybe_pause();
        if (!quiet && !squeeze && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Registers feed the pipeline live, so only touch them once it is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        cfg_t           phase_cfg;
        pix_vec_t       cur;
        pix_vec_t       grey;
        pix_vec_t       traj_pos;
        pix_vec_t       traj_grey;
        logic [PIX-1:0] traj_live;
        step_res_t      want;
        logic [2:0]     setting_now;
        int             near;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the first rows check the reset register values
        setting_now = SET_RESET;
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].setting != setting_now)
            begin
                settle();
                apply_cfg(dir_cfgs[dir_rows[r].setting]);
                setting_now = dir_rows[r].setting;
            end
            want = dir_rows[r].known ? dir_rows[r].res
                                     : advance_pixels(live_cfg, dir_rows[r].cur, dir_rows[r].grey);
            offer(dir_rows[r].cur, dir_rows[r].grey, want);
            maybe_pause();
        end

        // random phases: all-low, all-high and all-high windowed settings first, then random
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            settle();
            if (ph == 0)
                phase_cfg = '0;
            else if (ph == 1)
                phase_cfg = '{'1, 4'hF, 1'b1, 1'b1, 1'b1, 4'hF};
            else if (ph == 2)
                phase_cfg = '{'1, 4'hF, 1'b1, 1'b0, 1'b1, 4'hF};
            else
            begin
                phase_cfg.grey_table   = {$urandom, $urandom};
                phase_cfg.travel_gain  = nib_t'($urandom_range(0, 1) ? $urandom_range(2, 5)
                                                                     : $urandom_range(0, 15));
                phase_cfg.boost_enable = ($urandom_range(0, 3) != 0);
                phase_cfg.rested_mode  = ($urandom_range(0, 1) != 0);
                phase_cfg.fine_hold    = ($urandom_range(0, 2) == 0);
                // mostly small steps so windowed pixels actually move
                phase_cfg.frame_step   = nib_t'(($urandom_range(0, 3) == 0)
                                                ? $urandom_range(0, 15) : $urandom_range(1, 3));
            end
            apply_cfg(phase_cfg);
            squeeze   = (ph == SQUEEZE_PHASE);
            quiet     = (ph >= PHASE_COUNT - 2);
            traj_live = '0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                for (int i = 0; i < PIX; i++)
                begin
                    if (traj_live[i] && $urandom_range(0, 7) != 0)
                    begin
                        // keep walking; now and then the target grey changes mid-flight
                        cur[i]  = traj_pos[i];
                        grey[i] = ($urandom_range(0, 7) == 0) ? nib_t'($urandom) : traj_grey[i];
                    end
                    else
                    begin
                        grey[i] = nib_t'($urandom);
                        if ($urandom_range(0, 1))
                            cur[i] = nib_t'($urandom);
                        else
                        begin
                            near = int'($urandom_range(0, 8)) - 4
                                   + int'(target_of(live_cfg, grey[i]));
                            cur[i] = nib_t'((near < 0) ? 0 : ((near > 15) ? 15 : near));
                        end
                    end
                    traj_live[i] = 1'b1;
                end
                want = advance_pixels(live_cfg, cur, grey);
                traj_pos  = want.pos;
                traj_grey = grey;
                offer(cur, grey, want);
                maybe_pause();
            end
        end
        squeeze = 1'b0;

        in_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold-off during the
    // squeeze phase so the pipeline fills and pushes back on requests.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        bit held_off;
        int hold_cnt;
        held_off = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !held_off)
            begin
                out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_OFF_CYCLES; hold_cnt++)
                    @(posedge clk);
                out_stall <= 1'b0;
                held_off = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_steps.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request outstanding", $time);
            end
            else
            begin
                got_step = pending_steps.pop_front();
                check_field("new_pos_0", 8'(got_step.pos[0]), 8'(new_pos_0));
                check_field("new_pos_1", 8'(got_step.pos[1]), 8'(new_pos_1));
                check_field("new_pos_2", 8'(got_step.pos[2]), 8'(new_pos_2));
                check_field("new_pos_3", 8'(got_step.pos[3]), 8'(new_pos_3));
                check_field("drive_byte", got_step.drive, drive_byte);
                check_field("still_active", 8'(got_step.active), 8'(still_active));
                check_field("drove_any", 8'(got_step.drove), 8'(drove_any));
                check_field("want_coarse", 8'(got_step.coarse), 8'(want_coarse));
                check_field("want_fine", 8'(got_step.fine), 8'(want_fine));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
